// ===== src/dohm_pkg.sv =====
// Shared constants, beat types and a helper function for the divider ohmmeter.
package dohm_pkg;

	localparam int ADC_BITS    = 10;
	localparam int DIGIT_COUNT = 4;

	localparam int SAMPLE_W = 10;
	localparam int REF_W    = 16;
	localparam int OFS_W    = 4;
	localparam int RES_W    = 26;
	localparam int POSN_W   = 2;
	localparam int DIGIT_W  = 4;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	// Offset sample, product and quotient widths.
	localparam int A_W    = ADC_BITS + 1;
	localparam int PROD_W = REF_W + ADC_BITS;

	// Eight BCD digits cover every value below 2^26.
	localparam int BCD_DIGITS = 8;
	localparam int BCD_W      = BCD_DIGITS * DIGIT_W;

	localparam int CNT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	localparam logic [A_W-1:0] FULL_SCALE = A_W'((64'd1 << ADC_BITS) - 64'd1);
	localparam logic [63:0]    RES_MAX    = (64'd1 << RES_W) - 64'd1;

	localparam logic [REF_W-1:0] REF_RES_RESET = REF_W'(5100);
	localparam logic [OFS_W-1:0] CAL_OFS_RESET = OFS_W'(1);

	typedef enum logic {
		REG_REF_RES = 1'b0,
		REG_CAL_OFS = 1'b1
	} reg_idx_t;

	function automatic logic [63:0] ten_pow(input int n);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < n; i++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

	localparam logic [63:0] DIGIT_LIMIT = ten_pow(DIGIT_COUNT) - 64'd1;

	// One beat travelling through the divider cells.
	typedef struct packed {
		logic                valid;
		logic                sat;
		logic [ADC_BITS-1:0] divisor;
		logic [ADC_BITS-1:0] rem;
		logic [PROD_W-1:0]   word;
	} div_beat_t;

	// One beat travelling through the binary to BCD cells.
	typedef struct packed {
		logic             valid;
		logic             sat;
		logic             over;
		logic [RES_W-1:0] res;
		logic [RES_W-1:0] bin;
		logic [BCD_W-1:0] bcd;
	} bcd_beat_t;

endpackage

// ===== src/dohm_div_cell.sv =====
// One restoring division cell: produces one quotient bit per beat.
module dohm_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  dohm_pkg::div_beat_t in_beat,
	output dohm_pkg::div_beat_t out_beat
);
	import dohm_pkg::*;

	logic [ADC_BITS:0]   shifted;
	logic [ADC_BITS+1:0] diff;
	logic                fits;
	div_beat_t           nxt;

	always_comb begin
		shifted     = {in_beat.rem, in_beat.word[PROD_W-1]};
		diff        = {1'b0, shifted} - {2'b00, in_beat.divisor};
		fits        = !diff[ADC_BITS+1];
		nxt         = in_beat;
		nxt.rem     = fits ? diff[ADC_BITS-1:0] : shifted[ADC_BITS-1:0];
		nxt.word    = {in_beat.word[PROD_W-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_beat <= '0;
		end else begin
			out_beat <= nxt;
		end
	end

endmodule

// ===== src/dohm_bcd_cell.sv =====
// One shift-and-add-three cell: moves one binary bit into the BCD digits.
module dohm_bcd_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  dohm_pkg::bcd_beat_t in_beat,
	output dohm_pkg::bcd_beat_t out_beat
);
	import dohm_pkg::*;

	logic [BCD_W-1:0] adj;
	bcd_beat_t        nxt;

	always_comb begin
		adj = in_beat.bcd;
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if (in_beat.bcd[DIGIT_W*d +: DIGIT_W] >= 4'd5) begin
				adj[DIGIT_W*d +: DIGIT_W] = in_beat.bcd[DIGIT_W*d +: DIGIT_W] + 4'd3;
			end
		end
		nxt     = in_beat;
		nxt.bcd = {adj[BCD_W-2:0], in_beat.bin[RES_W-1]};
		nxt.bin = {in_beat.bin[RES_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_beat <= '0;
		end else begin
			out_beat <= nxt;
		end
	end

endmodule

// ===== src/divider_ohmmeter_bcd_display.sv =====
// Top level of the divider ohmmeter: sample intake, divider and BCD cell rows, digit output.
//
// Usage. A sample is taken on adc_sample at a rising edge where start is high and busy is
// low. The block adds calibration_offset and computes reference_resistor * a / (full_scale - a),
// pins a sample at or past full scale to over range and all nines, then sends one result
// beat per display digit, ones digit first, on consecutive cycles. Each beat is marked by valid
// for exactly one cycle and carries the digit, its position, the shared resistance and
// over_range flags; last is set on the most significant digit.
// Path: from the accepting edge a sample passes two intake stages, one divider cell per
// quotient bit, one clamp stage, one BCD cell per result bit and the output load; the
// remaining digits follow on the next cycles.
// Pacing is set by the digit output register, which sends one beat a cycle; busy stays
// high after an accept until the gap counter runs out, so a new sample can enter while
// earlier ones are still in the cell rows, which move a beat every cycle.
// The receiver cannot stall, so results are never held back.
// Reset (arst_n low) clears all valid flags and returns the two APB registers to 5100 ohms
// and an offset of one LSB. Registers are written over APB at byte addresses 0 and 4.
module divider_ohmmeter_bcd_display (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dohm_pkg::APB_AW-1:0]   paddr,
	input  logic [dohm_pkg::APB_DW-1:0]   pwdata,
	output logic [dohm_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	// Command channel.
	input  logic                          start,
	output logic                          busy,
	input  logic [dohm_pkg::SAMPLE_W-1:0] adc_sample,
	// Result channel.
	output logic                          valid,
	output logic [dohm_pkg::POSN_W-1:0]   digit_position,
	output logic [dohm_pkg::DIGIT_W-1:0]  bcd_digit,
	output logic [dohm_pkg::RES_W-1:0]    resistance,
	output logic                          over_range,
	output logic                          last
);
	import dohm_pkg::*;

	// Configuration registers.
	logic [REF_W-1:0] reference_resistor_q;
	logic [OFS_W-1:0] calibration_offset_q;
	logic             cfg_write;

	// Intake.
	logic [CNT_W-1:0]    gap_q;
	logic                accept;
	logic [A_W-1:0]      a_sum;
	logic                valid_s1;
	logic                sat_s1;
	logic [A_W-1:0]      a_s1;
	logic [ADC_BITS-1:0] mult_op;
	div_beat_t           div_s2;

	// Cell rows.
	div_beat_t div_chain [0:PROD_W];
	bcd_beat_t bcd_chain [0:RES_W];

	// Clamp stage.
	logic [PROD_W-1:0] quot;
	logic [RES_W-1:0]  res_clamped;
	bcd_beat_t         bcd_s3;

	// Digit output register.
	logic             active_q;
	logic [CNT_W-1:0] pos_q;
	logic [BCD_W-1:0] digits_q;
	logic [RES_W-1:0] res_q;
	logic             over_q;
	logic             sat_q;
	logic             pos_is_last;

	// ------------------------------------------------------------------
	// APB registers. Only address bit 2 selects the register; the port is
	// always ready, so a write lands at the end of its access cycle.
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_resistor_q <= REF_RES_RESET;
			calibration_offset_q <= CAL_OFS_RESET;
		end else if (cfg_write) begin
			case (reg_idx_t'(paddr[2]))
				REG_REF_RES: reference_resistor_q <= pwdata[REF_W-1:0];
				REG_CAL_OFS: calibration_offset_q <= pwdata[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_REF_RES: prdata = APB_DW'(reference_resistor_q);
			REG_CAL_OFS: prdata = APB_DW'(calibration_offset_q);
			default:     prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Intake pacing. After each accept, busy holds off the next sample until
	// the gap counter reaches zero, so that the digit beats of two samples
	// never overlap at the output.
	// ------------------------------------------------------------------
	assign busy   = (gap_q != '0);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (accept) begin
			gap_q <= CNT_W'(DIGIT_COUNT - 1);
		end else if (gap_q != '0) begin
			gap_q <= gap_q - 1'b1;
		end
	end

	// Stage 1: add the calibration offset and flag samples at or past full scale.
	assign a_sum = A_W'(ADC_BITS'(adc_sample)) + A_W'(calibration_offset_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		a_s1   <= a_sum;
		sat_s1 <= (a_sum >= FULL_SCALE);
	end

	// Stage 2: form the dividend. A saturated sample multiplies by
	// full_scale - 1 and divides by one, so the divider row passes the
	// product through unchanged.
	assign mult_op = sat_s1 ? ADC_BITS'(FULL_SCALE - 1'b1) : a_s1[ADC_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s2 <= '0;
		end else begin
			div_s2.valid   <= valid_s1;
			div_s2.sat     <= sat_s1;
			div_s2.divisor <= sat_s1 ? ADC_BITS'(1) : ADC_BITS'(FULL_SCALE - a_s1);
			div_s2.rem     <= '0;
			div_s2.word    <= PROD_W'(reference_resistor_q) * PROD_W'(mult_op);
		end
	end

	// ------------------------------------------------------------------
	// Divider row: one cell per quotient bit, most significant bit first.
	// Dividend bits leave the top of the word as quotient bits enter below.
	// ------------------------------------------------------------------
	assign div_chain[0] = div_s2;

	for (genvar i = 0; i < PROD_W; i++) begin : g_div
		dohm_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_beat  (div_chain[i]),
			.out_beat (div_chain[i+1])
		);
	end

	// Stage 3: clamp the quotient to the result width and decide over_range.
	assign quot        = div_chain[PROD_W].word;
	assign res_clamped = (quot > PROD_W'(RES_MAX)) ? RES_W'(RES_MAX) : quot[RES_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_s3 <= '0;
		end else begin
			bcd_s3.valid <= div_chain[PROD_W].valid;
			bcd_s3.sat   <= div_chain[PROD_W].sat;
			bcd_s3.over  <= div_chain[PROD_W].sat || (64'(res_clamped) > DIGIT_LIMIT);
			bcd_s3.res   <= res_clamped;
			bcd_s3.bin   <= res_clamped;
			bcd_s3.bcd   <= '0;
		end
	end

	// ------------------------------------------------------------------
	// Binary to BCD row: one shift-and-add-three cell per result bit.
	// ------------------------------------------------------------------
	assign bcd_chain[0] = bcd_s3;

	for (genvar j = 0; j < RES_W; j++) begin : g_bcd
		dohm_bcd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_beat  (bcd_chain[j]),
			.out_beat (bcd_chain[j+1])
		);
	end

	// ------------------------------------------------------------------
	// Digit output register. A finished sample loads here and is shifted
	// out one digit per cycle, ones first. The intake pacing spaces samples so
	// that a load only ever meets the last beat of the previous sample; the
	// load wins.
	// ------------------------------------------------------------------
	assign pos_is_last = (pos_q == CNT_W'(DIGIT_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= '0;
		end else if (bcd_chain[RES_W].valid) begin
			active_q <= 1'b1;
			pos_q    <= '0;
		end else if (active_q) begin
			active_q <= !pos_is_last;
			pos_q    <= pos_is_last ? '0 : pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (bcd_chain[RES_W].valid) begin
			digits_q <= bcd_chain[RES_W].bcd;
			res_q    <= bcd_chain[RES_W].res;
			over_q   <= bcd_chain[RES_W].over;
			sat_q    <= bcd_chain[RES_W].sat;
		end else if (active_q) begin
			digits_q <= {DIGIT_W'(0), digits_q[BCD_W-1:DIGIT_W]};
		end
	end

	assign valid          = active_q;
	assign digit_position = POSN_W'(pos_q);
	assign bcd_digit      = sat_q ? DIGIT_W'(9) : digits_q[DIGIT_W-1:0];
	assign resistance     = res_q;
	assign over_range     = over_q;
	assign last           = active_q && pos_is_last;

`ifndef SYNTHESIS
	// The digits of one sample leave on consecutive cycles.
	a_digits_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |=> valid)
		else $error("digit beats of one sample were interrupted");

	// Positions count up by one within a sample.
	a_position_steps: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |=> digit_position == $past(digit_position) + 2'd1)
		else $error("digit position did not advance by one");

	// A finished sample never lands in the middle of another one's digits.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_chain[RES_W].valid |-> (!valid || last))
		else $error("new sample overwrote digits still being sent");

	// Without over_range the value fits the display.
	a_fits_display: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !over_range |-> 64'(resistance) <= DIGIT_LIMIT)
		else $error("over_range clear on a value too wide for the display");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the divider ohmmeter with BCD digit output.
module testbench;
	import dohm_pkg::*;

	// Full scale of the converter and the widest resistance the result port can carry.
	localparam logic [63:0] FS64        = (64'd1 << ADC_BITS) - 64'd1;
	localparam logic [63:0] RES_CAP     = (64'd1 << RES_W) - 64'd1;
	// Largest value the display shows without flagging over range.
	localparam logic [63:0] DISPLAY_MAX = 64'(10 ** DIGIT_COUNT) - 64'd1;
	localparam int          BCD_LEN     = DIGIT_COUNT * DIGIT_W;

	localparam int RAND_PHASES  = 10;
	localparam int PHASE_ITEMS  = 30;
	localparam int MAX_GAP      = 17;
	// The tail waits a bit longer than the first digit beat trails the accept.
	localparam int TAIL_CYCLES  = 64;
	localparam int MAX_REPORTS  = 40;
	localparam int LIMIT_TIME   = 3_000_000;

	typedef enum logic {
		ROW_SAMPLE = 1'b0,
		ROW_WRITE  = 1'b1
	} row_kind_t;

	// One row of the directed table. A write row carries the register value in value; a
	// sample row carries the sample and, where typed is set, the reading it must produce.
	typedef struct packed {
		row_kind_t          kind;
		reg_idx_t           reg_sel;
		logic [31:0]        value;
		logic               typed;
		logic [RES_W-1:0]   ohms;
		logic               over;
		logic [BCD_LEN-1:0] bcd;
	} stim_row_t;

	// One digit beat as it should appear on the result ports.
	typedef struct packed {
		logic [POSN_W-1:0]  pos;
		logic [DIGIT_W-1:0] digit;
		logic [RES_W-1:0]   ohms;
		logic               over;
		logic               last;
	} digit_beat_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                start;
	logic                busy;
	logic [SAMPLE_W-1:0] adc_sample;
	logic                valid;
	logic [POSN_W-1:0]   digit_position;
	logic [DIGIT_W-1:0]  bcd_digit;
	logic [RES_W-1:0]    resistance;
	logic                over_range;
	logic                last;

	// Testbench copy of the two configuration registers.
	logic [REF_W-1:0] ref_ohms;
	logic [OFS_W-1:0] cal_lsb;

	// Digit beats still owed by the block, oldest first.
	digit_beat_t digit_beats_due[$];
	stim_row_t   directed_rows[$];

	int errors;
	int samples_sent;
	int beats_checked;
	int reg_writes;

	divider_ohmmeter_bcd_display dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.start          (start),
		.busy           (busy),
		.adc_sample     (adc_sample),
		.valid          (valid),
		.digit_position (digit_position),
		.bcd_digit      (bcd_digit),
		.resistance     (resistance),
		.over_range     (over_range),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case a handshake never completes or a beat never shows up.
	initial begin
		#LIMIT_TIME;
		$display("Timeout at %0t with %0d digit beats outstanding.", $time,
			digit_beats_due.size());
		$display("** divider_ohmmeter_bcd_display: FAILED **");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		errors++;
		if (errors <= MAX_REPORTS) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// Computes the reading of one sample under the current register copy. When the offset
	// sample reaches full scale the divisor would be zero or negative, so the reading is
	// pinned: over range, all nines, and the resistance of a one LSB divisor.
	function automatic void predict_reading(input logic [SAMPLE_W-1:0] sample,
		output logic [RES_W-1:0] ohms, output logic over, output logic [BCD_LEN-1:0] bcd);
		logic [63:0] a;
		logic [63:0] val;
		logic [63:0] left;
		logic        pinned;
		a      = (64'(sample) & FS64) + 64'(cal_lsb);
		pinned = (a >= FS64);
		if (pinned) begin
			val = 64'(ref_ohms) * (FS64 - 64'd1);
		end else begin
			val = (64'(ref_ohms) * a) / (FS64 - a);
		end
		if (val > RES_CAP) begin
			val = RES_CAP;
		end
		// Above the display range the digits still show the low decimal places.
		over = pinned || (val > DISPLAY_MAX);
		ohms = val[RES_W-1:0];
		left = val;
		for (int k = 0; k < DIGIT_COUNT; k++) begin
			bcd[k*DIGIT_W +: DIGIT_W] = pinned ? DIGIT_W'(9) : DIGIT_W'(left % 64'd10);
			left = left / 64'd10;
		end
	endfunction

	// Turns one reading into its digit beats, ones digit first, last on the top digit.
	task automatic queue_reading(input logic [RES_W-1:0] ohms, input logic over,
		input logic [BCD_LEN-1:0] bcd);
		digit_beat_t b;
		for (int k = 0; k < DIGIT_COUNT; k++) begin
			b.pos   = POSN_W'(k);
			b.digit = bcd[k*DIGIT_W +: DIGIT_W];
			b.ohms  = ohms;
			b.over  = over;
			b.last  = (k == DIGIT_COUNT - 1);
			digit_beats_due.push_back(b);
		end
	endtask

	task automatic add_row(input row_kind_t kind, input reg_idx_t reg_sel,
		input logic [31:0] value, input logic typed, input logic [RES_W-1:0] ohms,
		input logic over, input logic [BCD_LEN-1:0] bcd);
		stim_row_t r;
		r.kind    = kind;
		r.reg_sel = reg_sel;
		r.value   = value;
		r.typed   = typed;
		r.ohms    = ohms;
		r.over    = over;
		r.bcd     = bcd;
		directed_rows.push_back(r);
	endtask

	// Offers one sample after an idle gap and holds start until the block takes it. start
	// is left high after the accept; the next call either drops it or reuses it directly.
	task automatic send_sample(input stim_row_t row, input int gap);
		logic [RES_W-1:0]   ohms;
		logic               over;
		logic [BCD_LEN-1:0] bcd;
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start      <= 1'b1;
		adc_sample <= row.value[SAMPLE_W-1:0];
		do @(posedge clk); while (busy !== 1'b0);
		if (row.typed) begin
			queue_reading(row.ohms, row.over, row.bcd);
		end else begin
			predict_reading(row.value[SAMPLE_W-1:0], ohms, over, bcd);
			queue_reading(ohms, over, bcd);
		end
		samples_sent++;
	endtask

	// Brings the block to idle: no sample offered, every owed beat received, busy low.
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (digit_beats_due.size() != 0) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	task automatic apb_read_check(input reg_idx_t idx);
		logic [APB_DW-1:0] got;
		logic [APB_DW-1:0] want;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= APB_AW'({idx, 2'b00});
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		got  = prdata;
		want = (idx == REG_REF_RES) ? APB_DW'(ref_ohms) : APB_DW'(cal_lsb);
		if (got !== want) begin
			report((idx == REG_REF_RES) ? "reference_resistor readback" :
				"calibration_offset readback", want, got);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Setup cycle, then access cycle; the register copy follows at the completing edge.
	// Every write is read back.
	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (idx == REG_REF_RES) begin
			ref_ohms = value[REF_W-1:0];
		end else begin
			cal_lsb = value[OFS_W-1:0];
		end
		reg_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		apb_read_check(idx);
	endtask

	// Result checker. The block cannot be held off, so every strobed beat is taken at the
	// edge that ends its cycle and compared against the oldest owed beat.
	always @(posedge clk) begin : watch_digits
		digit_beat_t got;
		digit_beat_t want;
		if (arst_n === 1'b1 && valid === 1'b1) begin
			got = {digit_position, bcd_digit, resistance, over_range, last};
			if (digit_beats_due.size() == 0) begin
				report("unexpected digit beat, resistance", 32'd0, 32'(got.ohms));
			end else begin
				want = digit_beats_due.pop_front();
				beats_checked++;
				if (got.pos !== want.pos) begin
					report("digit_position", 32'(want.pos), 32'(got.pos));
				end
				if (got.digit !== want.digit) begin
					report("bcd_digit", 32'(want.digit), 32'(got.digit));
				end
				if (got.ohms !== want.ohms) begin
					report("resistance", 32'(want.ohms), 32'(got.ohms));
				end
				if (got.over !== want.over) begin
					report("over_range", 32'(want.over), 32'(got.over));
				end
				if (got.last !== want.last) begin
					report("last", 32'(want.last), 32'(got.last));
				end
			end
		end
	end

	initial begin : drive
		stim_row_t        row;
		logic [REF_W-1:0] pick_ref;
		logic [OFS_W-1:0] pick_ofs;
		logic             gapless;

		errors        = 0;
		samples_sent  = 0;
		beats_checked = 0;
		reg_writes    = 0;

		// All inputs known from time zero, with reset held low at the start.
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		start      = 1'b0;
		adc_sample = '0;
		ref_ohms   = REF_RES_RESET;
		cal_lsb    = CAL_OFS_RESET;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Registers must come out of reset at 5100 ohms and one LSB.
		apb_read_check(REG_REF_RES);
		apb_read_check(REG_CAL_OFS);

		// Directed table. The typed rows are the readings that follow directly from the
		// formula: reset values, the two ends of the sample range, a zero result, the
		// pinned full-scale reading and the widest resistance the block can produce.
		add_row(ROW_SAMPLE, REG_REF_RES, 0,    1'b1, 26'd4,        1'b0, 16'h0004);
		add_row(ROW_SAMPLE, REG_REF_RES, 1023, 1'b1, 26'd5212200,  1'b1, 16'h9999);
		add_row(ROW_SAMPLE, REG_REF_RES, 1022, 1'b1, 26'd5212200,  1'b1, 16'h9999);
		add_row(ROW_SAMPLE, REG_REF_RES, 1021, 1'b1, 26'd5212200,  1'b1, 16'h2200);
		add_row(ROW_SAMPLE, REG_REF_RES, 511,  1'b0, '0,           1'b0, '0);
		add_row(ROW_SAMPLE, REG_REF_RES, 682,  1'b0, '0,           1'b0, '0);
		add_row(ROW_WRITE,  REG_CAL_OFS, 0,    1'b0, '0,           1'b0, '0);
		add_row(ROW_SAMPLE, REG_REF_RES, 0,    1'b1, 26'd0,        1'b0, 16'h0000);
		add_row(ROW_SAMPLE, REG_REF_RES, 1022, 1'b1, 26'd5212200,  1'b1, 16'h2200);
		add_row(ROW_SAMPLE, REG_REF_RES, 1023, 1'b1, 26'd5212200,  1'b1, 16'h9999);
		add_row(ROW_SAMPLE, REG_REF_RES, 682,  1'b0, '0,           1'b0, '0);
		add_row(ROW_WRITE,  REG_REF_RES, 65535, 1'b0, '0,          1'b0, '0);
		add_row(ROW_SAMPLE, REG_REF_RES, 1022, 1'b1, 26'd66976770, 1'b1, 16'h6770);
		add_row(ROW_SAMPLE, REG_REF_RES, 1023, 1'b1, 26'd66976770, 1'b1, 16'h9999);
		add_row(ROW_SAMPLE, REG_REF_RES, 0,    1'b1, 26'd0,        1'b0, 16'h0000);
		add_row(ROW_SAMPLE, REG_REF_RES, 1,    1'b0, '0,           1'b0, '0);
		add_row(ROW_WRITE,  REG_CAL_OFS, 15,   1'b0, '0,           1'b0, '0);
		add_row(ROW_SAMPLE, REG_REF_RES, 1008, 1'b1, 26'd66976770, 1'b1, 16'h9999);
		add_row(ROW_SAMPLE, REG_REF_RES, 1007, 1'b1, 26'd66976770, 1'b1, 16'h6770);
		add_row(ROW_SAMPLE, REG_REF_RES, 0,    1'b0, '0,           1'b0, '0);
		add_row(ROW_WRITE,  REG_REF_RES, 1,    1'b0, '0,           1'b0, '0);
		add_row(ROW_SAMPLE, REG_REF_RES, 1007, 1'b0, '0,           1'b0, '0);
		add_row(ROW_SAMPLE, REG_REF_RES, 341,  1'b0, '0,           1'b0, '0);
		// A zero reference resistor gives zero ohms; at full scale it is also flagged over range.
		add_row(ROW_WRITE,  REG_REF_RES, 0,    1'b0, '0,           1'b0, '0);
		add_row(ROW_SAMPLE, REG_REF_RES, 100,  1'b1, 26'd0,        1'b0, 16'h0000);
		add_row(ROW_SAMPLE, REG_REF_RES, 1023, 1'b1, 26'd0,        1'b1, 16'h9999);
		// Straddle the display limit: 10000 ohms flags over range, 9998 does not.
		add_row(ROW_WRITE,  REG_REF_RES, 5000, 1'b0, '0,           1'b0, '0);
		add_row(ROW_WRITE,  REG_CAL_OFS, 0,    1'b0, '0,           1'b0, '0);
		add_row(ROW_SAMPLE, REG_REF_RES, 682,  1'b0, '0,           1'b0, '0);
		add_row(ROW_WRITE,  REG_REF_RES, 4999, 1'b0, '0,           1'b0, '0);
		add_row(ROW_SAMPLE, REG_REF_RES, 682,  1'b0, '0,           1'b0, '0);
		add_row(ROW_SAMPLE, REG_REF_RES, 930,  1'b0, '0,           1'b0, '0);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				settle();
				apb_write(directed_rows[i].reg_sel, directed_rows[i].value);
			end else begin
				send_sample(directed_rows[i], $urandom_range(0, MAX_GAP));
			end
		end

		// Random phases. Each phase sets both registers while the block is idle, the first
		// few at the extremes or the reset values, then streams samples. Some phases run back to
		// back so the accept lands right as busy drops; the rest draw a fresh gap per sample.
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			case (phase)
				0: begin
					pick_ref = 16'd65535;
					pick_ofs = 4'd15;
				end
				1: begin
					pick_ref = 16'd1;
					pick_ofs = 4'd0;
				end
				2: begin
					pick_ref = 16'd0;
					pick_ofs = OFS_W'($urandom_range(0, 15));
				end
				3: begin
					pick_ref = 16'd5100;
					pick_ofs = 4'd1;
				end
				default: begin
					// Half the phases keep the reference small so readings sit near the
					// display limit instead of always overflowing it.
					if ($urandom_range(0, 1) == 0) begin
						pick_ref = REF_W'($urandom_range(1, 20000));
					end else begin
						pick_ref = REF_W'($urandom_range(0, 65535));
					end
					pick_ofs = OFS_W'($urandom_range(0, 15));
				end
			endcase
			settle();
			apb_write(REG_REF_RES, 32'(pick_ref));
			apb_write(REG_CAL_OFS, 32'(pick_ofs));
			gapless = (phase % 3 == 1) || ($urandom_range(0, 4) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				row      = '0;
				row.kind = ROW_SAMPLE;
				case ($urandom_range(0, 9))
					// Close to full scale, where the offset can push past it.
					0, 1:    row.value = 32'(1023 - $urandom_range(0, 20));
					// Close to zero, where the result is a handful of ohms.
					2:       row.value = 32'($urandom_range(0, 15));
					default: row.value = 32'($urandom_range(0, 1023));
				endcase
				send_sample(row, gapless ? 0 : $urandom_range(0, MAX_GAP));
			end
		end

		// Drain every owed beat, then watch a little past the latency for strays.
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d samples and %0d digit beats, with %0d register writes.",
			samples_sent, beats_checked, reg_writes);
		$display("It reached full-scale pinning, zero and maximum reference, offsets 0 to 15.");
		if (errors == 0) begin
			$display("** divider_ohmmeter_bcd_display: PASSED **");
		end else begin
			$display("** divider_ohmmeter_bcd_display: FAILED **");
		end
		$finish;
	end

endmodule

// ===== divider_ohmmeter_bcd_display.f =====
src/dohm_pkg.sv
src/dohm_div_cell.sv
src/dohm_bcd_cell.sv
src/divider_ohmmeter_bcd_display.sv
dv/testbench.sv
